[rtl/core/sampled_table_interpolation_lookup_top_defines.svh]
// Assertion macros shared by the checker of the sampled table lookup.
`ifndef SAMPLED_TABLE_INTERPOLATION_LOOKUP_TOP_DEFINES_SVH
`define SAMPLED_TABLE_INTERPOLATION_LOOKUP_TOP_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define STIL_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define STIL_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/core/stil_pkg.sv]
// Package with the types and constants of the sampled table lookup.
`timescale 1ns / 1ps
package stil_pkg;

    localparam logic [1:0] MODE_LOAD_TIME  = 2'd0;
    localparam logic [1:0] MODE_LOAD_VALUE = 2'd1;
    localparam logic [1:0] MODE_QUERY      = 2'd2;

    localparam logic [1:0] CFG_SAMPLE_COUNT  = 2'd0;
    localparam logic [1:0] CFG_CHANNEL_COUNT = 2'd1;
    localparam logic [1:0] CFG_ANALOG_MASK   = 2'd2;

    localparam int DIV_STEPS = 33;

    typedef struct packed {
        logic [1:0]         mode;
        logic [9:0]         entry_index;
        logic [2:0]         channel;
        logic signed [47:0] time_value;
        logic signed [31:0] sample_value;
        logic               sample_valid;
    } in_item_t;

    typedef struct packed {
        logic signed [31:0] result_value;
        logic               result_valid;
    } out_item_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_RD_FIRST,
        S_RD_LAST,
        S_CHK_RANGE,
        S_SEARCH_RD,
        S_SEARCH_CMP,
        S_RD_I,
        S_RD_NEXT,
        S_EVAL,
        S_PREP,
        S_DIV,
        S_EMIT_NAN,
        S_EMIT_V0,
        S_EMIT_INT
    } state_t;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_RD_FIRST,
        OP_RD_LAST,
        OP_CHK_RANGE,
        OP_SEARCH_RD,
        OP_SEARCH_CMP,
        OP_RD_I,
        OP_RD_NEXT,
        OP_EVAL,
        OP_PREP,
        OP_DIV,
        OP_EMIT_NAN,
        OP_EMIT_V0,
        OP_EMIT_INT
    } dp_op_t;

    typedef struct packed {
        dp_op_t op;
        logic   accept;
    } ctrl_cmd_t;

    typedef struct packed {
        logic is_query;
        logic pre_ok;
        logic range_ok;
        logic search_more;
        logic hold;
        logic div_skip;
        logic div_last;
    } dp_status_t;

endpackage

[rtl/core/stil_ctrl.sv]
// Controller state machine that sequences search, fetch and divide.
`timescale 1ns / 1ps
module stil_ctrl
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  stil_pkg::dp_status_t status,
    output stil_pkg::ctrl_cmd_t  cmd,
    output logic                 busy
);

    stil_pkg::state_t state_reg;
    stil_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= stil_pkg::S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            stil_pkg::S_IDLE:
            begin
                if (start && status.is_query)
                begin
                    state_next = stil_pkg::S_RD_FIRST;
                end
            end
            stil_pkg::S_RD_FIRST:
            begin
                state_next = status.pre_ok ? stil_pkg::S_RD_LAST : stil_pkg::S_EMIT_NAN;
            end
            stil_pkg::S_RD_LAST:     state_next = stil_pkg::S_CHK_RANGE;
            stil_pkg::S_CHK_RANGE:
            begin
                state_next = status.range_ok ? stil_pkg::S_SEARCH_RD : stil_pkg::S_EMIT_NAN;
            end
            stil_pkg::S_SEARCH_RD:
            begin
                state_next = status.search_more ? stil_pkg::S_SEARCH_CMP : stil_pkg::S_RD_I;
            end
            stil_pkg::S_SEARCH_CMP:  state_next = stil_pkg::S_SEARCH_RD;
            stil_pkg::S_RD_I:        state_next = stil_pkg::S_RD_NEXT;
            stil_pkg::S_RD_NEXT:     state_next = stil_pkg::S_EVAL;
            stil_pkg::S_EVAL:
            begin
                state_next = status.hold ? stil_pkg::S_EMIT_V0 : stil_pkg::S_PREP;
            end
            stil_pkg::S_PREP:
            begin
                state_next = status.div_skip ? stil_pkg::S_EMIT_V0 : stil_pkg::S_DIV;
            end
            stil_pkg::S_DIV:
            begin
                if (status.div_last)
                begin
                    state_next = stil_pkg::S_EMIT_INT;
                end
            end
            stil_pkg::S_EMIT_NAN:    state_next = stil_pkg::S_IDLE;
            stil_pkg::S_EMIT_V0:     state_next = stil_pkg::S_IDLE;
            stil_pkg::S_EMIT_INT:    state_next = stil_pkg::S_IDLE;
            default:                 state_next = stil_pkg::S_IDLE;
        endcase
    end

    always_comb
    begin
        cmd.accept = 1'b0;
        cmd.op     = stil_pkg::OP_NONE;
        busy       = 1'b1;
        case (state_reg)
            stil_pkg::S_IDLE:
            begin
                busy       = 1'b0;
                cmd.accept = start;
            end
            stil_pkg::S_RD_FIRST:   cmd.op = stil_pkg::OP_RD_FIRST;
            stil_pkg::S_RD_LAST:    cmd.op = stil_pkg::OP_RD_LAST;
            stil_pkg::S_CHK_RANGE:  cmd.op = stil_pkg::OP_CHK_RANGE;
            stil_pkg::S_SEARCH_RD:  cmd.op = stil_pkg::OP_SEARCH_RD;
            stil_pkg::S_SEARCH_CMP: cmd.op = stil_pkg::OP_SEARCH_CMP;
            stil_pkg::S_RD_I:       cmd.op = stil_pkg::OP_RD_I;
            stil_pkg::S_RD_NEXT:    cmd.op = stil_pkg::OP_RD_NEXT;
            stil_pkg::S_EVAL:       cmd.op = stil_pkg::OP_EVAL;
            stil_pkg::S_PREP:       cmd.op = stil_pkg::OP_PREP;
            stil_pkg::S_DIV:        cmd.op = stil_pkg::OP_DIV;
            stil_pkg::S_EMIT_NAN:   cmd.op = stil_pkg::OP_EMIT_NAN;
            stil_pkg::S_EMIT_V0:    cmd.op = stil_pkg::OP_EMIT_V0;
            stil_pkg::S_EMIT_INT:   cmd.op = stil_pkg::OP_EMIT_INT;
            default:                cmd.op = stil_pkg::OP_NONE;
        endcase
    end

endmodule

[rtl/core/stil_datapath.sv]
// Datapath with the tables, configuration, search registers and serial divider.
`timescale 1ns / 1ps
module stil_datapath
#(
    parameter int SAMPLE_DEPTH      = 1024,
    parameter int CHANNEL_COUNT_MAX = 8
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  stil_pkg::ctrl_cmd_t  cmd,
    output stil_pkg::dp_status_t status,
    input  stil_pkg::in_item_t   request,
    input  logic                 cfg_valid,
    input  logic [1:0]           cfg_index,
    input  logic [10:0]          cfg_data,
    output stil_pkg::out_item_t  result,
    output logic                 result_strobe
);

    localparam int AW  = $clog2(SAMPLE_DEPTH);
    localparam int CW  = $clog2(SAMPLE_DEPTH + 1);
    localparam int VD  = SAMPLE_DEPTH * CHANNEL_COUNT_MAX;
    localparam int VAW = (VD > 1) ? $clog2(VD) : 1;

    logic signed [47:0] time_mem [SAMPLE_DEPTH];
    logic [32:0]        value_mem [VD];

    logic [10:0] sample_count_reg;
    logic [3:0]  channel_count_reg;
    logic [7:0]  analog_mask_reg;

    logic signed [47:0] tm_q_reg;
    logic [32:0]        vm_q_reg;
    logic [AW-1:0]      tm_addr;
    logic [VAW-1:0]     vm_addr;

    logic signed [47:0] t_reg;
    logic [2:0]         ch_reg;
    logic               below_reg;
    logic [CW-1:0]      lo_reg;
    logic [CW-1:0]      hi_reg;
    logic [CW-1:0]      mid_reg;
    logic [CW-1:0]      i_reg;
    logic signed [47:0] t0_reg;
    logic signed [31:0] v0_reg;
    logic               v0ok_reg;
    logic signed [48:0] dt_reg;
    logic signed [48:0] r_reg;
    logic [32:0]        dabs_reg;
    logic               dneg_reg;
    logic [47:0]        rem_reg;
    logic [32:0]        q_reg;
    logic [5:0]         cnt_reg;
    stil_pkg::out_item_t result_reg;
    logic               strobe_reg;

    logic [CW-1:0]      n_eff;
    logic [CW-1:0]      mid_c;
    logic [CW-1:0]      i_c;
    logic [CW-1:0]      i_inc;
    logic signed [32:0] d_c;
    logic [49:0]        s_c;
    logic [49:0]        dt1_c;
    logic [49:0]        dt2_c;

    always_comb
    begin
        if (int'(sample_count_reg) > SAMPLE_DEPTH)
        begin
            n_eff = CW'(SAMPLE_DEPTH);
        end
        else
        begin
            n_eff = CW'(sample_count_reg);
        end
    end

    assign mid_c = lo_reg + ((hi_reg - lo_reg) >> 1);
    assign i_c   = (lo_reg == '0) ? '0 : lo_reg - CW'(1);
    assign i_inc = i_reg + CW'(1);
    assign d_c   = {vm_q_reg[31], vm_q_reg[31:0]} - {v0_reg[31], v0_reg};
    assign s_c   = {1'b0, rem_reg, 1'b0} + (dabs_reg[32] ? {2'b00, r_reg[47:0]} : 50'd0);
    assign dt1_c = {2'b00, dt_reg[47:0]};
    assign dt2_c = {1'b0, dt_reg[47:0], 1'b0};

    always_comb
    begin
        case (cmd.op)
            stil_pkg::OP_RD_LAST:   tm_addr = AW'(n_eff - CW'(1));
            stil_pkg::OP_SEARCH_RD: tm_addr = AW'(mid_c);
            stil_pkg::OP_RD_I:      tm_addr = AW'(i_c);
            stil_pkg::OP_RD_NEXT:   tm_addr = AW'(i_inc);
            stil_pkg::OP_EVAL:      tm_addr = AW'(i_inc);
            default:                tm_addr = '0;
        endcase
    end

    assign vm_addr = VAW'(int'(ch_reg) * SAMPLE_DEPTH + int'(tm_addr));

    assign status.is_query    = (request.mode == stil_pkg::MODE_QUERY);
    assign status.pre_ok      = (int'(ch_reg) < int'(channel_count_reg))
                                && (int'(ch_reg) < CHANNEL_COUNT_MAX) && (n_eff != '0);
    assign status.range_ok    = !below_reg && !(t_reg > tm_q_reg);
    assign status.search_more = (lo_reg < hi_reg);
    assign status.hold        = !analog_mask_reg[ch_reg] || (i_inc >= n_eff)
                                || !v0ok_reg || !vm_q_reg[32];
    assign status.div_skip    = (dt_reg <= 49'sd0) || (r_reg < 49'sd0) || (r_reg >= dt_reg);
    assign status.div_last    = (cnt_reg == 6'(stil_pkg::DIV_STEPS - 1));

    always_ff @(posedge clk)
    begin
        if (cmd.accept && (request.mode == stil_pkg::MODE_LOAD_TIME)
            && (int'(request.entry_index) < SAMPLE_DEPTH))
        begin
            time_mem[AW'(request.entry_index)] <= request.time_value;
        end
        tm_q_reg <= time_mem[tm_addr];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept && (request.mode == stil_pkg::MODE_LOAD_VALUE)
            && (int'(request.entry_index) < SAMPLE_DEPTH)
            && (int'(request.channel) < CHANNEL_COUNT_MAX))
        begin
            value_mem[VAW'(int'(request.channel) * SAMPLE_DEPTH + int'(request.entry_index))]
                <= {request.sample_valid, request.sample_value};
        end
        vm_q_reg <= value_mem[vm_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sample_count_reg  <= '0;
            channel_count_reg <= '0;
            analog_mask_reg   <= '0;
            strobe_reg        <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                case (cfg_index)
                    stil_pkg::CFG_SAMPLE_COUNT:  sample_count_reg  <= cfg_data;
                    stil_pkg::CFG_CHANNEL_COUNT: channel_count_reg <= cfg_data[3:0];
                    stil_pkg::CFG_ANALOG_MASK:   analog_mask_reg   <= cfg_data[7:0];
                    default:                     analog_mask_reg   <= analog_mask_reg;
                endcase
            end
            strobe_reg <= (cmd.op == stil_pkg::OP_EMIT_NAN) || (cmd.op == stil_pkg::OP_EMIT_V0)
                          || (cmd.op == stil_pkg::OP_EMIT_INT);
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            t_reg  <= request.time_value;
            ch_reg <= request.channel;
        end
        case (cmd.op)
            stil_pkg::OP_RD_LAST:   below_reg <= (t_reg < tm_q_reg);
            stil_pkg::OP_CHK_RANGE:
            begin
                lo_reg <= '0;
                hi_reg <= n_eff;
            end
            stil_pkg::OP_SEARCH_RD: mid_reg <= mid_c;
            stil_pkg::OP_SEARCH_CMP:
            begin
                if (tm_q_reg > t_reg)
                begin
                    hi_reg <= mid_reg;
                end
                else
                begin
                    lo_reg <= mid_reg + CW'(1);
                end
            end
            stil_pkg::OP_RD_I:      i_reg <= i_c;
            stil_pkg::OP_RD_NEXT:
            begin
                t0_reg   <= tm_q_reg;
                v0_reg   <= vm_q_reg[31:0];
                v0ok_reg <= vm_q_reg[32];
            end
            stil_pkg::OP_EVAL:
            begin
                dt_reg   <= {tm_q_reg[47], tm_q_reg} - {t0_reg[47], t0_reg};
                r_reg    <= {t_reg[47], t_reg} - {t0_reg[47], t0_reg};
                dneg_reg <= d_c[32];
                dabs_reg <= d_c[32] ? 33'(-d_c) : 33'(d_c);
            end
            stil_pkg::OP_PREP:
            begin
                rem_reg <= '0;
                q_reg   <= '0;
                cnt_reg <= '0;
            end
            stil_pkg::OP_DIV:
            begin
                if (s_c >= dt2_c)
                begin
                    rem_reg <= 48'(s_c - dt2_c);
                    q_reg   <= {q_reg[31:0], 1'b0} + 33'd2;
                end
                else if (s_c >= dt1_c)
                begin
                    rem_reg <= 48'(s_c - dt1_c);
                    q_reg   <= {q_reg[31:0], 1'b0} + 33'd1;
                end
                else
                begin
                    rem_reg <= 48'(s_c);
                    q_reg   <= {q_reg[31:0], 1'b0};
                end
                dabs_reg <= {dabs_reg[31:0], 1'b0};
                cnt_reg  <= cnt_reg + 6'd1;
            end
            stil_pkg::OP_EMIT_NAN:
            begin
                result_reg.result_value <= '0;
                result_reg.result_valid <= 1'b0;
            end
            stil_pkg::OP_EMIT_V0:
            begin
                result_reg.result_value <= v0_reg;
                result_reg.result_valid <= v0ok_reg;
            end
            stil_pkg::OP_EMIT_INT:
            begin
                result_reg.result_value <= v0_reg + (dneg_reg ? -q_reg[31:0] : q_reg[31:0]);
                result_reg.result_valid <= 1'b1;
            end
            default:
            begin
                i_reg <= i_reg;
            end
        endcase
    end

    assign result        = result_reg;
    assign result_strobe = strobe_reg;

endmodule

[rtl/core/sampled_table_interpolation_lookup_top.sv]
// Top level of the sampled table lookup with linear interpolation.
//
//   Channel   Handshake              Payload
//   request   start / busy           request (stil_pkg::in_item_t)
//   result    result_strobe          result (stil_pkg::out_item_t)
//   config    cfg_valid / cfg_ready  cfg_index, cfg_data
//
// A load request is written when it is accepted; busy stays low. A query passes
// through the range check (RD_FIRST, RD_LAST, CHK_RANGE), a binary search of at
// most ceil(log2(n+1)) probes (SEARCH_RD, SEARCH_CMP) and a closing SEARCH_RD, the
// fetch (RD_I, RD_NEXT, EVAL, PREP), the radix-2 divider and the output step.
// Queries that end early (out of range, held value) skip the later steps. Reset clears
// the configuration and the controller; the tables hold nothing defined until loaded.
// Each result shows for one idle cycle, in which the next request can be accepted.
`timescale 1ns / 1ps
module sampled_table_interpolation_lookup_top
#(
    parameter int SAMPLE_DEPTH      = 1024,
    parameter int CHANNEL_COUNT_MAX = 8
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  stil_pkg::in_item_t  request,
    output logic                result_strobe,
    output stil_pkg::out_item_t result,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [1:0]          cfg_index,
    input  logic [10:0]         cfg_data
);

    stil_pkg::ctrl_cmd_t  cmd;
    stil_pkg::dp_status_t status;

    assign cfg_ready = 1'b1;

    stil_ctrl u_ctrl
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .status (status),
        .cmd    (cmd),
        .busy   (busy)
    );

    stil_datapath
    #(
        .SAMPLE_DEPTH      (SAMPLE_DEPTH),
        .CHANNEL_COUNT_MAX (CHANNEL_COUNT_MAX)
    )
    u_datapath
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .status        (status),
        .request       (request),
        .cfg_valid     (cfg_valid),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .result        (result),
        .result_strobe (result_strobe)
    );

endmodule

[rtl/core/stil_checker.sv]
// Port checker of the sampled table lookup and its bind to the top level.
`timescale 1ns / 1ps
`include "sampled_table_interpolation_lookup_top_defines.svh"
module stil_checker
(
    input logic                clk,
    input logic                rst_n,
    input logic                start,
    input logic                busy,
    input stil_pkg::in_item_t  request,
    input logic                result_strobe
);

    `STIL_ASSERT_NEXT(a_strobe_single, result_strobe, !result_strobe, "result strobe held")
    `STIL_ASSERT_NEXT(a_query_busy, start && !busy && (request.mode == stil_pkg::MODE_QUERY), busy, "query did not raise busy")
    `STIL_ASSERT_NEXT(a_load_silent, start && !busy && (request.mode != stil_pkg::MODE_QUERY), !result_strobe && !busy, "load request gave a result")
    `STIL_ASSERT_NOW(a_strobe_idle, result_strobe, !busy, "result shown while busy")

endmodule

bind sampled_table_interpolation_lookup_top stil_checker u_stil_checker
(
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .request       (request),
    .result_strobe (result_strobe)
);
